@@ rtl/vph_pkg.sv @@
// Package: widths, codes, word types and helper functions of the voxel primitive hit test.
`timescale 1ns / 1ps
package vph_pkg;

  // Field and arithmetic widths.
  localparam int IO_W   = 16;             // width of one packed coordinate lane
  localparam int CW     = 16;             // significant coordinate bits, at most IO_W
  localparam int DW     = CW + 1;         // signed difference of two coordinates
  localparam int SQ_W   = 2 * CW;         // square of a difference magnitude
  localparam int D2_W   = 2 * CW + 2;     // sum of three squares
  localparam int PR_W   = 2 * DW;         // signed product of two differences
  localparam int DOT_W  = 2 * DW + 2;     // sum of three signed products
  localparam int CR_W   = 2 * DW + 1;     // cross product component
  localparam int LHS_W  = 4 * DW + 2;     // squared length of the cross product
  localparam int R_W    = 15;             // radius and thickness
  localparam int R2_W   = 2 * R_W;        // squared radius
  localparam int RL_W   = R2_W + D2_W;    // squared radius times squared segment length
  localparam int TAG_W  = 16;
  localparam int KIND_W = 3;
  localparam int PT_W   = 3 * IO_W;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THICKNESS  = 3'd4;

  // Primitive kinds.
  localparam logic [KIND_W-1:0] KIND_PARTICLE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SPHERE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CAPSULE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BOX      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WIRE     = 3'd4;

  // Primitive as seen by the front and back parts, with values derived from it.
  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [2:0][DW-1:0]     a;
    logic [2:0][DW-1:0]     b;
    logic [2:0][DW-1:0]     lo;
    logic [2:0][DW-1:0]     hi;
    logic [2:0][DW-1:0]     v;
    logic [R_W-1:0]         thk;
    logic [R2_W-1:0]        r2;
    logic [R2_W-1:0]        inner2;
    logic [R2_W-1:0]        t2;
    logic [RL_W-1:0]        rlen;
  } cfg_t;

  // One classified point, as queued between front and back.
  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [KIND_W-1:0]      kind;
    logic [2:0][DW-1:0]     w1;      // P - A
    logic [2:0][DW-1:0]     w2;      // P - B
    logic [2:0][CW-1:0]     o;       // distance outside the box span per axis
    logic [2:0][CW-1:0]     n;       // distance to the nearer box face per axis
    logic                   in_box;
    logic                   core;
  } entry_t;

  // Sign-extends the significant bits of one coordinate lane.
  function automatic logic signed [DW-1:0] sext_lane(input logic [IO_W-1:0] lane);
    return DW'(signed'(lane[CW-1:0]));
  endfunction

  // Magnitude of a coordinate difference.
  function automatic logic [CW-1:0] absd(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] m;
    m = d[DW-1] ? -d : d;
    return m[CW-1:0];
  endfunction

  // Magnitude of a cross product component.
  function automatic logic [2*DW-1:0] absc(input logic signed [CR_W-1:0] c);
    logic signed [CR_W-1:0] m;
    m = c[CR_W-1] ? -c : c;
    return m[2*DW-1:0];
  endfunction

endpackage

@@ rtl/vph_if.sv @@
// Interfaces of the point channel and the result channel.
`timescale 1ns / 1ps
interface vph_in_if;
  import vph_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IO_W-1:0]  point_x;
  logic signed [IO_W-1:0]  point_y;
  logic signed [IO_W-1:0]  point_z;
  logic [TAG_W-1:0]        point_tag;
  modport source (output valid, point_x, point_y, point_z, point_tag, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_tag, output ready);
endinterface

interface vph_out_if;
  import vph_pkg::*;
  logic              valid;
  logic              ready;
  logic [TAG_W-1:0]  tag_out;
  logic              hit;
  modport source (output valid, tag_out, hit, input ready);
  modport sink   (input valid, tag_out, hit, output ready);
endinterface

@@ rtl/vph_cfg.sv @@
// Configuration registers and the values derived from them.
`timescale 1ns / 1ps
module vph_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vph_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vph_pkg::PT_W-1:0]      cfg_wdata,
  output vph_pkg::cfg_t                 cfg
);
  import vph_pkg::*;

  logic [KIND_W-1:0]   kind_r;
  logic [PT_W-1:0]     pa_r;
  logic [PT_W-1:0]     pb_r;
  logic [R_W-1:0]      rad_r;
  logic [R_W-1:0]      thk_r;

  logic [2:0][DW-1:0]  a_s, b_s, lo_s, hi_s;
  logic [2:0][DW-1:0]  v_r, v_nxt;
  logic [2:0][SQ_W-1:0] vsq_r, vsq_nxt;
  logic [D2_W-1:0]     len2_r, len2_nxt;
  logic [R2_W-1:0]     r2_r, inner2_r, t2_r;
  logic [R2_W-1:0]     r2_nxt, inner2_nxt, t2_nxt;
  logic [R_W-1:0]      inner;
  logic [R2_W+DW-1:0]  rl_lo_r, rl_lo_nxt;
  logic [RL_W-DW-1:0]  rl_hi_r, rl_hi_nxt;
  logic [RL_W-1:0]     rlen_r, rlen_nxt;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= '0;
      pa_r   <= '0;
      pb_r   <= '0;
      rad_r  <= '0;
      thk_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SHAPE_KIND: kind_r <= cfg_wdata[KIND_W-1:0];
        REG_POINT_A:    pa_r   <= cfg_wdata;
        REG_POINT_B:    pb_r   <= cfg_wdata;
        REG_RADIUS:     rad_r  <= cfg_wdata[R_W-1:0];
        REG_THICKNESS:  thk_r  <= cfg_wdata[R_W-1:0];
        default: ;
      endcase
    end
  end

  // Corner coordinates and the box span.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_s[i]  = sext_lane(pa_r[i*IO_W +: IO_W]);
      b_s[i]  = sext_lane(pb_r[i*IO_W +: IO_W]);
      lo_s[i] = (signed'(a_s[i]) < signed'(b_s[i])) ? a_s[i] : b_s[i];
      hi_s[i] = (signed'(a_s[i]) < signed'(b_s[i])) ? b_s[i] : a_s[i];
    end
  end

  // Derived products, one multiplication per step.
  always_comb begin
    inner      = (rad_r > thk_r) ? rad_r - thk_r : '0;
    r2_nxt     = R2_W'(rad_r) * R2_W'(rad_r);
    inner2_nxt = R2_W'(inner) * R2_W'(inner);
    t2_nxt     = R2_W'(thk_r) * R2_W'(thk_r);
    for (int i = 0; i < 3; i++) begin
      v_nxt[i]   = DW'(signed'(b_s[i]) - signed'(a_s[i]));
      vsq_nxt[i] = SQ_W'(absd(v_r[i])) * SQ_W'(absd(v_r[i]));
    end
    len2_nxt  = D2_W'(vsq_r[0]) + D2_W'(vsq_r[1]) + D2_W'(vsq_r[2]);
    rl_lo_nxt = (R2_W+DW)'(r2_r) * (R2_W+DW)'(len2_r[DW-1:0]);
    rl_hi_nxt = (RL_W-DW)'(r2_r) * (RL_W-DW)'(len2_r[D2_W-1:DW]);
    rlen_nxt  = (RL_W'(rl_hi_r) << DW) + RL_W'(rl_lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      vsq_r    <= '0;
      len2_r   <= '0;
      r2_r     <= '0;
      inner2_r <= '0;
      t2_r     <= '0;
      rl_lo_r  <= '0;
      rl_hi_r  <= '0;
      rlen_r   <= '0;
    end else begin
      v_r      <= v_nxt;
      vsq_r    <= vsq_nxt;
      len2_r   <= len2_nxt;
      r2_r     <= r2_nxt;
      inner2_r <= inner2_nxt;
      t2_r     <= t2_nxt;
      rl_lo_r  <= rl_lo_nxt;
      rl_hi_r  <= rl_hi_nxt;
      rlen_r   <= rlen_nxt;
    end
  end

  assign cfg.kind   = kind_r;
  assign cfg.a      = a_s;
  assign cfg.b      = b_s;
  assign cfg.lo     = lo_s;
  assign cfg.hi     = hi_s;
  assign cfg.v      = v_r;
  assign cfg.thk    = thk_r;
  assign cfg.r2     = r2_r;
  assign cfg.inner2 = inner2_r;
  assign cfg.t2     = t2_r;
  assign cfg.rlen   = rlen_r;

endmodule

@@ rtl/vph_front.sv @@
// Front part: accepts points and classifies them against the primitive.
`timescale 1ns / 1ps
module vph_front (
  input  logic            clk,
  input  logic            rst_n,
  vph_in_if.sink          in_ch,
  input  vph_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            q_push,
  output vph_pkg::entry_t q_data
);
  import vph_pkg::*;

  logic                      f_valid_r, f_valid_nxt;
  entry_t                    f_data_r, f_data_nxt;
  logic [2:0][DW-1:0]        p_s;
  logic signed [DW:0]        t_e, p_e, lo_e, hi_e;
  logic [CW-1:0]             d_lo, d_hi;
  logic                      accept;

  assign in_ch.ready = !f_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = f_valid_r && !q_full;
  assign q_data      = f_data_r;

  // Differences, box flags and wireframe distances of the incoming point.
  always_comb begin
    p_s[0] = sext_lane(in_ch.point_x);
    p_s[1] = sext_lane(in_ch.point_y);
    p_s[2] = sext_lane(in_ch.point_z);
    t_e    = signed'({{(DW+1-R_W){1'b0}}, cfg.thk});
    f_data_nxt.tag    = in_ch.point_tag;
    f_data_nxt.kind   = cfg.kind;
    f_data_nxt.in_box = 1'b1;
    f_data_nxt.core   = 1'b1;
    p_e  = '0;
    lo_e = '0;
    hi_e = '0;
    d_lo = '0;
    d_hi = '0;
    for (int i = 0; i < 3; i++) begin
      f_data_nxt.w1[i] = DW'(signed'(p_s[i]) - signed'(cfg.a[i]));
      f_data_nxt.w2[i] = DW'(signed'(p_s[i]) - signed'(cfg.b[i]));
      p_e  = (DW+1)'(signed'(p_s[i]));
      lo_e = (DW+1)'(signed'(cfg.lo[i]));
      hi_e = (DW+1)'(signed'(cfg.hi[i]));
      if (!(lo_e < p_e && hi_e > p_e)) begin
        f_data_nxt.in_box = 1'b0;
      end
      if (!(lo_e + t_e < p_e && hi_e - t_e > p_e)) begin
        f_data_nxt.core = 1'b0;
      end
      d_lo = absd(DW'(signed'(p_s[i]) - signed'(cfg.lo[i])));
      d_hi = absd(DW'(signed'(p_s[i]) - signed'(cfg.hi[i])));
      if (p_e < lo_e) begin
        f_data_nxt.o[i] = d_lo;
      end else if (p_e > hi_e) begin
        f_data_nxt.o[i] = d_hi;
      end else begin
        f_data_nxt.o[i] = '0;
      end
      f_data_nxt.n[i] = (d_lo < d_hi) ? d_lo : d_hi;
    end
  end

  // Holding register in front of the queue.
  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data_r <= f_data_nxt;
    end
  end

endmodule

@@ rtl/vph_queue.sv @@
// Short queue of classified points between the front and back parts.
`timescale 1ns / 1ps
module vph_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vph_pkg::entry_t wr_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output vph_pkg::entry_t head_data
);
  import vph_pkg::*;

  entry_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ rtl/vph_back.sv @@
// Back part: distance arithmetic pipeline and the result register.
`timescale 1ns / 1ps
module vph_back (
  input  logic            clk,
  input  logic            rst_n,
  input  vph_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  vph_pkg::entry_t head_data,
  output logic            pop,
  vph_out_if.source       out_ch
);
  import vph_pkg::*;

  logic adv;

  // Stage 1: products.
  logic                     s1_v_r;
  logic [TAG_W-1:0]         s1_tag_r;
  logic [KIND_W-1:0]        s1_kind_r;
  logic                     s1_in_box_r, s1_core_r;
  logic [2:0][SQ_W-1:0]     s1_sqa_r, s1_sqa_nxt, s1_sqb_r, s1_sqb_nxt;
  logic [2:0][SQ_W-1:0]     s1_so_r, s1_so_nxt, s1_sn_r, s1_sn_nxt;
  logic [2:0][PR_W-1:0]     s1_pd1_r, s1_pd1_nxt, s1_pd2_r, s1_pd2_nxt;
  logic [5:0][PR_W-1:0]     s1_cp_r, s1_cp_nxt;
  logic signed [PR_W-1:0]   w1e [3];
  logic signed [PR_W-1:0]   w2e [3];
  logic signed [PR_W-1:0]   ve  [3];

  // Stage 2: sums.
  logic                     s2_v_r;
  logic [TAG_W-1:0]         s2_tag_r;
  logic [KIND_W-1:0]        s2_kind_r;
  logic                     s2_in_box_r, s2_core_r;
  logic [D2_W-1:0]          s2_d2a_r, s2_d2a_nxt, s2_d2b_r, s2_d2b_nxt;
  logic [DOT_W-1:0]         s2_dot1_r, s2_dot1_nxt, s2_dot2_r, s2_dot2_nxt;
  logic [2:0][CR_W-1:0]     s2_c_r, s2_c_nxt;
  logic [2:0][D2_W-1:0]     s2_ws_r, s2_ws_nxt;

  // Stage 3: decisions and partial squares of the cross product.
  logic                     s3_v_r;
  logic [TAG_W-1:0]         s3_tag_r;
  logic                     s3_line_r, s3_line_nxt;
  logic                     s3_flag_r, s3_flag_nxt;
  logic [2:0][PR_W-1:0]     s3_hh_r, s3_hh_nxt, s3_hl_r, s3_hl_nxt, s3_ll_r, s3_ll_nxt;
  logic [2*DW-1:0]          cmag;
  logic [D2_W-1:0]          r2e, in2e, t2e;
  logic                     end_a, end_b, thk_nz;

  // Stage 4 and 5: squared cross product length.
  logic                     s4_v_r;
  logic [TAG_W-1:0]         s4_tag_r;
  logic                     s4_line_r, s4_flag_r;
  logic [2:0][LHS_W-1:0]    s4_csq_r, s4_csq_nxt;
  logic                     s5_v_r;
  logic [TAG_W-1:0]         s5_tag_r;
  logic                     s5_line_r, s5_flag_r;
  logic [LHS_W-1:0]         s5_lhs_r, s5_lhs_nxt;

  // Result register.
  logic                     out_valid_r;
  logic [TAG_W-1:0]         out_tag_r;
  logic                     out_hit_r, out_hit_nxt;

  // The whole pipeline moves when the result register is free or being taken.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head_valid;

  // Stage 1 products of the queued point.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w1e[i] = PR_W'(signed'(head_data.w1[i]));
      w2e[i] = PR_W'(signed'(head_data.w2[i]));
      ve[i]  = PR_W'(signed'(cfg.v[i]));
      s1_sqa_nxt[i] = SQ_W'(absd(head_data.w1[i])) * SQ_W'(absd(head_data.w1[i]));
      s1_sqb_nxt[i] = SQ_W'(absd(head_data.w2[i])) * SQ_W'(absd(head_data.w2[i]));
      s1_so_nxt[i]  = SQ_W'(head_data.o[i]) * SQ_W'(head_data.o[i]);
      s1_sn_nxt[i]  = SQ_W'(head_data.n[i]) * SQ_W'(head_data.n[i]);
      s1_pd1_nxt[i] = w1e[i] * ve[i];
      s1_pd2_nxt[i] = w2e[i] * ve[i];
    end
    s1_cp_nxt[0] = ve[1] * w1e[2];
    s1_cp_nxt[1] = ve[2] * w1e[1];
    s1_cp_nxt[2] = ve[2] * w1e[0];
    s1_cp_nxt[3] = ve[0] * w1e[2];
    s1_cp_nxt[4] = ve[0] * w1e[1];
    s1_cp_nxt[5] = ve[1] * w1e[0];
  end

  // Stage 2 sums: distances, end dot products, cross product, wire distances.
  always_comb begin
    s2_d2a_nxt  = D2_W'(s1_sqa_r[0]) + D2_W'(s1_sqa_r[1]) + D2_W'(s1_sqa_r[2]);
    s2_d2b_nxt  = D2_W'(s1_sqb_r[0]) + D2_W'(s1_sqb_r[1]) + D2_W'(s1_sqb_r[2]);
    s2_dot1_nxt = DOT_W'(signed'(s1_pd1_r[0])) + DOT_W'(signed'(s1_pd1_r[1]))
                + DOT_W'(signed'(s1_pd1_r[2]));
    s2_dot2_nxt = DOT_W'(signed'(s1_pd2_r[0])) + DOT_W'(signed'(s1_pd2_r[1]))
                + DOT_W'(signed'(s1_pd2_r[2]));
    for (int i = 0; i < 3; i++) begin
      s2_c_nxt[i] = CR_W'(signed'(s1_cp_r[2*i])) - CR_W'(signed'(s1_cp_r[2*i+1]));
    end
    s2_ws_nxt[0] = D2_W'(s1_so_r[0]) + D2_W'(s1_sn_r[1]) + D2_W'(s1_sn_r[2]);
    s2_ws_nxt[1] = D2_W'(s1_sn_r[0]) + D2_W'(s1_so_r[1]) + D2_W'(s1_sn_r[2]);
    s2_ws_nxt[2] = D2_W'(s1_sn_r[0]) + D2_W'(s1_sn_r[1]) + D2_W'(s1_so_r[2]);
  end

  // Stage 3: per-kind decision, and the cross product split into halves.
  always_comb begin
    r2e    = D2_W'(cfg.r2);
    in2e   = D2_W'(cfg.inner2);
    t2e    = D2_W'(cfg.t2);
    thk_nz = (cfg.thk != '0);
    end_b  = !s2_dot1_r[DOT_W-1] && !s2_dot2_r[DOT_W-1];
    end_a  = (s2_dot1_r[DOT_W-1] || s2_dot1_r == '0)
          && (s2_dot2_r[DOT_W-1] || s2_dot2_r == '0);
    s3_line_nxt = 1'b0;
    case (s2_kind_r)
      KIND_PARTICLE: s3_flag_nxt = (s2_d2a_r <= r2e);
      KIND_SPHERE:   s3_flag_nxt = (s2_d2a_r < r2e) && !(thk_nz && s2_d2a_r < in2e);
      KIND_CAPSULE: begin
        s3_flag_nxt = end_b ? (s2_d2b_r < r2e) : (s2_d2a_r < r2e);
        s3_line_nxt = !end_b && !end_a;
      end
      KIND_BOX:      s3_flag_nxt = s2_in_box_r && !(thk_nz && s2_core_r);
      KIND_WIRE:     s3_flag_nxt = (s2_ws_r[0] < t2e) || (s2_ws_r[1] < t2e)
                                || (s2_ws_r[2] < t2e);
      default:       s3_flag_nxt = 1'b0;
    endcase
    cmag = '0;
    for (int i = 0; i < 3; i++) begin
      cmag         = absc(s2_c_r[i]);
      s3_hh_nxt[i] = PR_W'(cmag[2*DW-1:DW]) * PR_W'(cmag[2*DW-1:DW]);
      s3_hl_nxt[i] = PR_W'(cmag[2*DW-1:DW]) * PR_W'(cmag[DW-1:0]);
      s3_ll_nxt[i] = PR_W'(cmag[DW-1:0]) * PR_W'(cmag[DW-1:0]);
    end
  end

  // Stage 4 and 5: reassemble the squares and total them.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_csq_nxt[i] = (LHS_W'(s3_hh_r[i]) << (2*DW)) + (LHS_W'(s3_hl_r[i]) << (DW+1))
                    + LHS_W'(s3_ll_r[i]);
    end
    s5_lhs_nxt  = s4_csq_r[0] + s4_csq_r[1] + s4_csq_r[2];
    out_hit_nxt = s5_line_r ? (s5_lhs_r < LHS_W'(cfg.rlen)) : s5_flag_r;
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= head_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      out_valid_r <= s5_v_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r    <= head_data.tag;
      s1_kind_r   <= head_data.kind;
      s1_in_box_r <= head_data.in_box;
      s1_core_r   <= head_data.core;
      s1_sqa_r    <= s1_sqa_nxt;
      s1_sqb_r    <= s1_sqb_nxt;
      s1_so_r     <= s1_so_nxt;
      s1_sn_r     <= s1_sn_nxt;
      s1_pd1_r    <= s1_pd1_nxt;
      s1_pd2_r    <= s1_pd2_nxt;
      s1_cp_r     <= s1_cp_nxt;

      s2_tag_r    <= s1_tag_r;
      s2_kind_r   <= s1_kind_r;
      s2_in_box_r <= s1_in_box_r;
      s2_core_r   <= s1_core_r;
      s2_d2a_r    <= s2_d2a_nxt;
      s2_d2b_r    <= s2_d2b_nxt;
      s2_dot1_r   <= s2_dot1_nxt;
      s2_dot2_r   <= s2_dot2_nxt;
      s2_c_r      <= s2_c_nxt;
      s2_ws_r     <= s2_ws_nxt;

      s3_tag_r    <= s2_tag_r;
      s3_line_r   <= s3_line_nxt;
      s3_flag_r   <= s3_flag_nxt;
      s3_hh_r     <= s3_hh_nxt;
      s3_hl_r     <= s3_hl_nxt;
      s3_ll_r     <= s3_ll_nxt;

      s4_tag_r    <= s3_tag_r;
      s4_line_r   <= s3_line_r;
      s4_flag_r   <= s3_flag_r;
      s4_csq_r    <= s4_csq_nxt;

      s5_tag_r    <= s4_tag_r;
      s5_line_r   <= s4_line_r;
      s5_flag_r   <= s4_flag_r;
      s5_lhs_r    <= s5_lhs_nxt;

      out_tag_r   <= s5_tag_r;
      out_hit_r   <= out_hit_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.tag_out = out_tag_r;
  assign out_ch.hit     = out_hit_r;

endmodule

@@ rtl/voxel_primitive_hit_test.sv @@
// Top level of the voxel primitive hit test.
`timescale 1ns / 1ps
// Tests each incoming display point against one primitive (particle, sphere or shell,
// capsule, solid or hollow box, wireframe box) held in the configuration registers and
// returns the point's tag with a hit flag. One point word is accepted every clock cycle
// for as long as results are taken; on its way to the output a point passes a holding
// register, a two-entry queue, five arithmetic stages and the result register, a depth
// set by the multiply-and-sum stages of the back pipeline. After the output has been
// held back, the full queue stalls intake as it starts to drain. The user must write
// registers through the cfg_ port only while no point is in flight; the block itself
// does not enforce this. Products derived from them (squared radii, squared segment
// length times squared radius) settle through registers before a point accepted after
// the write reaches them.
module voxel_primitive_hit_test (
  input  logic                          clk,
  input  logic                          rst_n,
  vph_in_if.sink                        in_ch,
  vph_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [vph_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vph_pkg::PT_W-1:0]      cfg_wdata
);
  import vph_pkg::*;

  cfg_t   cfg;
  entry_t q_wr_data, q_head_data;
  logic   q_full, q_push, q_pop, q_head_valid;

  // Primitive registers.
  vph_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Point intake and classification.
  vph_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  // Decoupling queue.
  vph_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr_data    (q_wr_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  // Arithmetic pipeline and result register.
  vph_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
